### rtl/core/pfwq_pkg.sv
// ----------------------------------------------------------------------------
// Priority wait queue package
// Shared widths, default sizes, opcode and status codes, and scan status type.
// ----------------------------------------------------------------------------
package pfwq_pkg;

    localparam int OPCODE_W        = 2;
    localparam int ID_W            = 5;
    localparam int PRIO_W          = 6;
    localparam int STATUS_W        = 2;

    localparam int NUM_WAITERS_DEF = 32;
    localparam int PRIO_LEVELS_DEF = 64;

    localparam int SCAN_W          = 16;
    localparam int SCAN_IDX_W      = $clog2(SCAN_W);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHOOSE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_QUEUED = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_ALREADY    = 2'd3
    } status_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

endpackage

### rtl/core/pfwq_top_scan.sv
// ----------------------------------------------------------------------------
// Priority wait queue occupancy scanner
// Finds the highest occupied level, one SCAN_W-bit chunk per cycle from the top.
// ----------------------------------------------------------------------------
module pfwq_top_scan
    import pfwq_pkg::*;
#(
    parameter int   PRIO_LEVELS = PRIO_LEVELS_DEF,
    localparam int  LVL_W       = $clog2(PRIO_LEVELS)
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [PRIO_LEVELS-1:0] occ,
    output scan_status_t           scan_st,
    output logic [LVL_W-1:0]       level
);

    localparam int NCHUNK  = (PRIO_LEVELS + SCAN_W - 1) / SCAN_W;
    localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W   = NCHUNK * SCAN_W;
    localparam int FULL_W  = CHUNK_W + SCAN_IDX_W;

    logic                  busy_reg;
    logic                  busy_next;
    logic [CHUNK_W-1:0]    chunk_reg;
    logic [CHUNK_W-1:0]    chunk_next;
    logic [PAD_W-1:0]      occ_pad;
    logic [SCAN_W-1:0]     chunk_bits;
    logic [SCAN_IDX_W-1:0] idx;
    logic                  hit;
    logic [FULL_W-1:0]     full_level;

    assign occ_pad    = PAD_W'(occ);
    assign chunk_bits = occ_pad[chunk_reg * SCAN_W +: SCAN_W];
    assign hit        = |chunk_bits;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < SCAN_W; i++)
        begin
            if (chunk_bits[i])
            begin
                idx = SCAN_IDX_W'(i);
            end
        end
    end

    assign full_level    = {chunk_reg, idx};
    assign level         = full_level[LVL_W-1:0];
    assign scan_st.done  = busy_reg & (hit | (chunk_reg == '0));
    assign scan_st.found = busy_reg & hit;

    always_comb
    begin
        busy_next  = busy_reg;
        chunk_next = chunk_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            chunk_next = CHUNK_W'(NCHUNK - 1);
        end
        else if (busy_reg)
        begin
            if (scan_st.done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                chunk_next = chunk_reg - CHUNK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            chunk_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            chunk_reg <= chunk_next;
        end
    end

endmodule

### rtl/core/priority_fifo_wait_queue.sv
// ----------------------------------------------------------------------------
// Priority FIFO wait queue
// Per-level linked lists of waiters with an occupancy bitmap; add, remove and
// choose-highest under a multi-cycle sequencer.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; req_ready is high only while the
// sequencer waits for a request. The occupancy scanner looks at 16 levels per
// cycle from the top, over at most ceil(PRIO_LEVELS/16) chunks, and stops at
// the first occupied chunk. Every operation ends with one scan that reports
// the new top priority; a choose first runs another scan to pick the level,
// also on an empty queue. Every list update goes through single-port-read,
// single-port-write memories with registered read data, which sets the
// read-then-write steps. A full result register decouples the response side.
// After reset the block runs a clearing pass over every entry of the
// waiter-queued memory and holds req_ready low until it finishes.
module priority_fifo_wait_queue
    import pfwq_pkg::*;
#(
    parameter int NUM_WAITERS = NUM_WAITERS_DEF,
    parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [ID_W-1:0]     waiter_id,
    input  logic [PRIO_W-1:0]   priority_req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     chosen_waiter,
    output logic                queue_empty,
    output logic [PRIO_W-1:0]   top_priority
);

    localparam int WID_W      = $clog2(NUM_WAITERS);
    localparam int LVL_W      = $clog2(PRIO_LEVELS);
    localparam int ID_EXT_W   = WID_W + ID_W;
    localparam int PRIO_EXT_W = LVL_W + PRIO_W;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_ADD    = 9'b000000100,
        S_RCHK   = 9'b000001000,
        S_CSCAN  = 9'b000010000,
        S_CHEAD  = 9'b000100000,
        S_UNLINK = 9'b001000000,
        S_FSCAN  = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    // list memories
    logic [2*WID_W-1:0] lvl_mem [PRIO_LEVELS];
    logic [WID_W-1:0]   nxt_mem [NUM_WAITERS];
    logic [WID_W-1:0]   prv_mem [NUM_WAITERS];
    logic [LVL_W-1:0]   wlv_mem [NUM_WAITERS];
    logic               que_mem [NUM_WAITERS];

    state_t             state_reg,   state_next;
    logic [WID_W-1:0]   w_reg,       w_next;
    logic               id_ok_reg,   id_ok_next;
    logic [LVL_W-1:0]   lvl_reg,     lvl_next;
    status_t            st_reg,      st_next;
    logic [WID_W-1:0]   chosen_reg,  chosen_next;
    logic [LVL_W-1:0]   top_reg,     top_next;
    logic               empty_reg,   empty_next;
    logic [WID_W-1:0]   clr_reg,     clr_next;
    logic [PRIO_LEVELS-1:0] occ_reg, occ_next;

    logic               rsp_valid_reg, rsp_valid_next;
    status_t            status_reg,    status_next;
    logic [WID_W-1:0]   chs_out_reg,   chs_out_next;
    logic               qempty_reg,    qempty_next;
    logic [LVL_W-1:0]   top_out_reg,   top_out_next;

    logic [WID_W-1:0]   nxt_rd_reg;
    logic [WID_W-1:0]   prv_rd_reg;
    logic [LVL_W-1:0]   wlv_rd_reg;
    logic               que_rd_reg;
    logic [WID_W-1:0]   head_rd_reg;
    logic [WID_W-1:0]   tail_rd_reg;

    logic               wrd_re;
    logic [WID_W-1:0]   wrd_addr;
    logic               lrd_re;
    logic [LVL_W-1:0]   lrd_addr;

    logic               nxt_we;
    logic [WID_W-1:0]   nxt_waddr, nxt_wdata;
    logic               prv_we;
    logic [WID_W-1:0]   prv_waddr, prv_wdata;
    logic               wlv_we;
    logic               que_we;
    logic [WID_W-1:0]   que_waddr;
    logic               que_wdata;
    logic               lvl_we;
    logic [LVL_W-1:0]   lvl_waddr;
    logic [2*WID_W-1:0] lvl_wdata;

    logic               scan_start;
    scan_status_t       scan_st;
    logic [LVL_W-1:0]   scan_level;

    logic [ID_EXT_W-1:0]   id_ext;
    logic                  id_ok;
    logic [WID_W-1:0]      id_idx;
    logic [PRIO_EXT_W-1:0] prio_ext;
    logic [LVL_W-1:0]      prio_lvl;
    logic [ID_EXT_W-1:0]   chs_ext;
    logic [PRIO_EXT_W-1:0] top_ext;
    logic                  req_xfer;
    logic                  is_head;
    logic                  is_tail;

    pfwq_top_scan #(
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .occ     (occ_reg),
        .scan_st (scan_st),
        .level   (scan_level)
    );

    assign id_ext   = ID_EXT_W'(waiter_id);
    assign id_ok    = id_ext < ID_EXT_W'(NUM_WAITERS);
    assign id_idx   = id_ext[WID_W-1:0];
    assign prio_ext = PRIO_EXT_W'(priority_req);
    assign prio_lvl = (prio_ext >= PRIO_EXT_W'(PRIO_LEVELS)) ? LVL_W'(PRIO_LEVELS - 1)
                                                             : prio_ext[LVL_W-1:0];

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid & req_ready;
    assign is_head   = (head_rd_reg == w_reg);
    assign is_tail   = (tail_rd_reg == w_reg);

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        id_ok_next     = id_ok_reg;
        lvl_next       = lvl_reg;
        st_next        = st_reg;
        chosen_next    = chosen_reg;
        top_next       = top_reg;
        empty_next     = empty_reg;
        clr_next       = clr_reg;
        occ_next       = occ_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        status_next    = status_reg;
        chs_out_next   = chs_out_reg;
        qempty_next    = qempty_reg;
        top_out_next   = top_out_reg;

        wrd_re    = 1'b0;
        wrd_addr  = w_reg;
        lrd_re    = 1'b0;
        lrd_addr  = lvl_reg;
        nxt_we    = 1'b0;
        nxt_waddr = w_reg;
        nxt_wdata = w_reg;
        prv_we    = 1'b0;
        prv_waddr = w_reg;
        prv_wdata = tail_rd_reg;
        wlv_we    = 1'b0;
        que_we    = 1'b0;
        que_waddr = w_reg;
        que_wdata = 1'b0;
        lvl_we    = 1'b0;
        lvl_waddr = lvl_reg;
        lvl_wdata = {head_rd_reg, tail_rd_reg};
        scan_start = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                que_we    = 1'b1;
                que_waddr = clr_reg;
                que_wdata = 1'b0;
                clr_next  = clr_reg + WID_W'(1);
                if (clr_reg == WID_W'(NUM_WAITERS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    w_next      = id_idx;
                    id_ok_next  = id_ok;
                    lvl_next    = prio_lvl;
                    st_next     = ST_OK;
                    chosen_next = '0;
                    wrd_re      = 1'b1;
                    wrd_addr    = id_idx;
                    lrd_re      = 1'b1;
                    lrd_addr    = prio_lvl;
                    unique case (op_t'(opcode))
                        OP_ADD:    state_next = S_ADD;
                        OP_REMOVE: state_next = S_RCHK;
                        OP_CHOOSE:
                        begin
                            scan_start = 1'b1;
                            state_next = S_CSCAN;
                        end
                        OP_NOP:
                        begin
                            scan_start = 1'b1;
                            state_next = S_FSCAN;
                        end
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                priority if (!id_ok_reg)
                begin
                    st_next = ST_NOT_QUEUED;
                end
                else if (que_rd_reg)
                begin
                    st_next = ST_ALREADY;
                end
                else
                begin
                    // append at tail of level
                    nxt_we    = occ_reg[lvl_reg];
                    nxt_waddr = tail_rd_reg;
                    nxt_wdata = w_reg;
                    prv_we    = 1'b1;
                    prv_waddr = w_reg;
                    prv_wdata = tail_rd_reg;
                    wlv_we    = 1'b1;
                    que_we    = 1'b1;
                    que_waddr = w_reg;
                    que_wdata = 1'b1;
                    lvl_we    = 1'b1;
                    lvl_waddr = lvl_reg;
                    lvl_wdata = occ_reg[lvl_reg] ? {head_rd_reg, w_reg} : {w_reg, w_reg};
                    occ_next[lvl_reg] = 1'b1;
                end
                scan_start = 1'b1;
                state_next = S_FSCAN;
            end
            S_RCHK:
            begin
                if (!id_ok_reg || !que_rd_reg)
                begin
                    st_next    = ST_NOT_QUEUED;
                    scan_start = 1'b1;
                    state_next = S_FSCAN;
                end
                else
                begin
                    lvl_next   = wlv_rd_reg;
                    lrd_re     = 1'b1;
                    lrd_addr   = wlv_rd_reg;
                    state_next = S_UNLINK;
                end
            end
            S_CSCAN:
            begin
                if (scan_st.done)
                begin
                    if (scan_st.found)
                    begin
                        lvl_next   = scan_level;
                        lrd_re     = 1'b1;
                        lrd_addr   = scan_level;
                        state_next = S_CHEAD;
                    end
                    else
                    begin
                        st_next    = ST_EMPTY;
                        scan_start = 1'b1;
                        state_next = S_FSCAN;
                    end
                end
            end
            S_CHEAD:
            begin
                w_next      = head_rd_reg;
                chosen_next = head_rd_reg;
                wrd_re      = 1'b1;
                wrd_addr    = head_rd_reg;
                state_next  = S_UNLINK;
            end
            S_UNLINK:
            begin
                priority if (is_head && is_tail)
                begin
                    occ_next[lvl_reg] = 1'b0;
                end
                else if (is_head)
                begin
                    lvl_we    = 1'b1;
                    lvl_wdata = {nxt_rd_reg, tail_rd_reg};
                end
                else if (is_tail)
                begin
                    lvl_we    = 1'b1;
                    lvl_wdata = {head_rd_reg, prv_rd_reg};
                end
                else
                begin
                    // bridge neighbors
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_rd_reg;
                    nxt_wdata = nxt_rd_reg;
                    prv_we    = 1'b1;
                    prv_waddr = nxt_rd_reg;
                    prv_wdata = prv_rd_reg;
                end
                que_we     = 1'b1;
                que_waddr  = w_reg;
                que_wdata  = 1'b0;
                scan_start = 1'b1;
                state_next = S_FSCAN;
            end
            S_FSCAN:
            begin
                if (scan_st.done)
                begin
                    empty_next = ~scan_st.found;
                    top_next   = scan_st.found ? scan_level : '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = st_reg;
                    chs_out_next   = chosen_reg;
                    qempty_next    = empty_reg;
                    top_out_next   = top_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg       <= w_next;
        id_ok_reg   <= id_ok_next;
        lvl_reg     <= lvl_next;
        st_reg      <= st_next;
        chosen_reg  <= chosen_next;
        top_reg     <= top_next;
        empty_reg   <= empty_next;
        status_reg  <= status_next;
        chs_out_reg <= chs_out_next;
        qempty_reg  <= qempty_next;
        top_out_reg <= top_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wrd_re)
        begin
            nxt_rd_reg <= nxt_mem[wrd_addr];
            prv_rd_reg <= prv_mem[wrd_addr];
            wlv_rd_reg <= wlv_mem[wrd_addr];
            que_rd_reg <= que_mem[wrd_addr];
        end
        if (lrd_re)
        begin
            {head_rd_reg, tail_rd_reg} <= lvl_mem[lrd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (prv_we)
        begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
        if (wlv_we)
        begin
            wlv_mem[w_reg] <= lvl_reg;
        end
        if (que_we)
        begin
            que_mem[que_waddr] <= que_wdata;
        end
        if (lvl_we)
        begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
    end

    assign chs_ext = ID_EXT_W'(chs_out_reg);
    assign top_ext = PRIO_EXT_W'(top_out_reg);

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign chosen_waiter = chs_ext[ID_W-1:0];
    assign queue_empty   = qempty_reg;
    assign top_priority  = top_ext[PRIO_W-1:0];

endmodule
